FILE: hdl/crtc_pkg.sv
// ----------------------------------------------------------------------------
// crtc_pkg: shared types, constants and calendar functions
// Holds the request and time records and the leap-year and month-length
// helpers used by the clock core and the top level.
// ----------------------------------------------------------------------------
package crtc_pkg;

    localparam logic [1:0] OpTick = 2'd0;
    localparam logic [1:0] OpSet  = 2'd1;
    localparam logic [1:0] OpRead = 2'd2;

    localparam logic [15:0] TicksPerSecondReset = 16'd1000;
    localparam logic [15:0] YearReset           = 16'd2000;

    localparam logic [6:0] SecondMax = 7'd59;
    localparam logic [6:0] MinuteMax = 7'd59;
    localparam logic [5:0] HourMax   = 6'd23;
    localparam logic [4:0] MonthMax  = 5'd12;
    localparam logic [4:0] HourLimit = 5'd24;
    localparam logic [5:0] MinLimit  = 6'd60;

    // Multiplicative inverse of 25 modulo 2^16 and the largest quotient of
    // a 16-bit multiple of 25; together they give an exact divisibility test.
    localparam logic [15:0] Inv25    = 16'd23593;
    localparam logic [15:0] Div25Max = 16'd2621;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } time_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [2:0]  set_weekday;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        logic        set_leap;
    } req_t;

    // A year is divisible by 100 when it is divisible by 4 and by 25, and
    // by 400 when it is divisible by 16 and by 25.
    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = 32'(y) * 32'(Inv25);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod[15:0] <= Div25Max);
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hdl/crtc_core.sv
// ----------------------------------------------------------------------------
// crtc_core: time-of-day and calendar state with next-state logic
// Holds the sub-second counter, the calendar registers and the tick rate,
// and computes the time after one request in a single pass.
// ----------------------------------------------------------------------------
module crtc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                step,
    input  crtc_pkg::req_t      req,
    output crtc_pkg::time_t     time_next,
    output logic                pulse_next
);

    logic [15:0]     tps_reg;
    logic [15:0]     tick_count_reg;
    logic [15:0]     tick_count_next;
    crtc_pkg::time_t now_reg;
    crtc_pkg::time_t adv;
    crtc_pkg::time_t setv;
    crtc_pkg::time_t nxt;

    logic [16:0] tick_inc;
    logic        roll;
    logic        leap_now;
    logic        leap_set;
    logic [4:0]  len_now;
    logic [4:0]  len_set;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic        year_ok;

    assign leap_now = crtc_pkg::is_leap(now_reg.year);
    assign len_now  = crtc_pkg::month_length(now_reg.month, leap_now);
    assign tick_inc = {1'b0, tick_count_reg} + 17'd1;
    assign roll     = (tick_inc >= {1'b0, tps_reg});

    // Carry chain from seconds up to the year.
    always_comb
    begin
        adv       = now_reg;
        sec_inc   = {1'b0, now_reg.second} + 7'd1;
        min_inc   = {1'b0, now_reg.minute} + 7'd1;
        hour_inc  = {1'b0, now_reg.hour} + 6'd1;
        day_inc   = {1'b0, now_reg.day} + 6'd1;
        month_inc = {1'b0, now_reg.month} + 5'd1;
        if (sec_inc <= crtc_pkg::SecondMax)
        begin
            adv.second = sec_inc[5:0];
        end
        else
        begin
            adv.second = 6'd0;
            if (min_inc <= crtc_pkg::MinuteMax)
            begin
                adv.minute = min_inc[5:0];
            end
            else
            begin
                adv.minute = 6'd0;
                if (hour_inc <= crtc_pkg::HourMax)
                begin
                    adv.hour = hour_inc[4:0];
                end
                else
                begin
                    adv.hour = 5'd0;
                    // A day left beyond the month by a set also carries here.
                    if (day_inc <= {1'b0, len_now})
                    begin
                        adv.day = day_inc[4:0];
                    end
                    else
                    begin
                        adv.day = 5'd1;
                        if (month_inc <= crtc_pkg::MonthMax)
                        begin
                            adv.month = month_inc[3:0];
                        end
                        else
                        begin
                            adv.month = 4'd1;
                            adv.year  = now_reg.year + 16'd1;
                        end
                    end
                end
            end
        end
    end

    // Each field of a set is checked on its own; the day is checked against
    // the month and year in force after this set.
    always_comb
    begin
        setv    = now_reg;
        year_ok = (req.set_year != 16'd0);
        if (req.set_hour < crtc_pkg::HourLimit)
        begin
            setv.hour = req.set_hour;
        end
        if (req.set_minute < crtc_pkg::MinLimit)
        begin
            setv.minute = req.set_minute;
        end
        if (req.set_second < crtc_pkg::MinLimit)
        begin
            setv.second = req.set_second;
        end
        if ((req.set_month >= 4'd1) && ({1'b0, req.set_month} <= crtc_pkg::MonthMax))
        begin
            setv.month = req.set_month;
        end
        if (req.set_weekday != 3'd0)
        begin
            setv.weekday = req.set_weekday;
        end
        if (year_ok)
        begin
            setv.year = req.set_year;
        end
        leap_set = year_ok ? req.set_leap : leap_now;
        len_set  = crtc_pkg::month_length(setv.month, leap_set);
        if ((req.set_day != 5'd0) && (req.set_day <= len_set))
        begin
            setv.day = req.set_day;
        end
    end

    always_comb
    begin
        nxt             = now_reg;
        tick_count_next = tick_count_reg;
        pulse_next      = 1'b0;
        case (req.op)
            crtc_pkg::OpTick:
            begin
                if (roll)
                begin
                    tick_count_next = 16'd0;
                    pulse_next      = 1'b1;
                    nxt             = adv;
                end
                else
                begin
                    tick_count_next = tick_inc[15:0];
                end
            end
            crtc_pkg::OpSet:
            begin
                nxt = setv;
            end
            default:
            begin
                nxt = now_reg;
            end
        endcase
    end

    assign time_next = nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= crtc_pkg::TicksPerSecondReset;
        end
        else if (cfg_we)
        begin
            tps_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= 16'd0;
            now_reg.year    <= crtc_pkg::YearReset;
            now_reg.month   <= 4'd1;
            now_reg.day     <= 5'd1;
            now_reg.weekday <= 3'd1;
            now_reg.hour    <= 5'd0;
            now_reg.minute  <= 6'd0;
            now_reg.second  <= 6'd0;
        end
        else if (step)
        begin
            tick_count_reg <= tick_count_next;
            now_reg        <= nxt;
        end
    end

endmodule

FILE: hdl/calendar_rtc_with_validated_set.sv
// ----------------------------------------------------------------------------
// calendar_rtc_with_validated_set: real-time clock and Gregorian calendar
// Counts ticks, by default millisecond ticks, into a full date and time, and
// takes validated time set and read requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_valid/in_ready channel; op selects a tick, a set
// or a read (the unused code reads). Every accepted word yields exactly one
// result word on out_valid/out_ready carrying the time after the request and
// second_pulse, high when that tick started a new second.
// The path is an input register followed by a result register, and one
// word is taken every cycle as long as the receiver keeps out_ready high.
// Next-state work fits in the single pass from the input register to the
// calendar state and result register; the set year is leap-tested before it.
// When the receiver stalls, the result is held and the input register still
// takes one more word; after that in_ready drops until out_ready returns.
// ticks_per_second is written through cfg_we/cfg_wdata; the user must write
// it only while idle, as the block does not enforce it. Reset (rst_n low)
// empties both registers and sets 2000-01-01 00:00:00, weekday 1, a zero
// tick count and 1000 ticks per second.
// ----------------------------------------------------------------------------
module calendar_rtc_with_validated_set (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [2:0]  set_weekday,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [5:0]  set_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cur_year,
    output logic [3:0]  cur_month,
    output logic [4:0]  cur_day,
    output logic [2:0]  cur_weekday,
    output logic [4:0]  cur_hour,
    output logic [5:0]  cur_minute,
    output logic [5:0]  cur_second,
    output logic        second_pulse
);

    logic             s1_valid_reg;
    crtc_pkg::req_t   req_reg;
    crtc_pkg::req_t   req_next;
    logic             out_valid_reg;
    crtc_pkg::time_t  out_time_reg;
    logic             out_pulse_reg;
    crtc_pkg::time_t  time_next;
    logic             pulse_next;
    logic             out_advance;
    logic             step;
    logic             in_fire;

    assign out_advance = !out_valid_reg || out_ready;
    assign step        = s1_valid_reg && out_advance;
    assign in_ready    = !s1_valid_reg || out_advance;
    assign in_fire     = in_valid && in_ready;

    // The leap test of the requested year is done ahead of the input register.
    always_comb
    begin
        req_next.op          = op;
        req_next.set_year    = set_year;
        req_next.set_month   = set_month;
        req_next.set_day     = set_day;
        req_next.set_weekday = set_weekday;
        req_next.set_hour    = set_hour;
        req_next.set_minute  = set_minute;
        req_next.set_second  = set_second;
        req_next.set_leap    = crtc_pkg::is_leap(set_year);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_next;
        end
    end

    crtc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .step       (step),
        .req        (req_reg),
        .time_next  (time_next),
        .pulse_next (pulse_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_time_reg  <= time_next;
            out_pulse_reg <= pulse_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cur_year     = out_time_reg.year;
    assign cur_month    = out_time_reg.month;
    assign cur_day      = out_time_reg.day;
    assign cur_weekday  = out_time_reg.weekday;
    assign cur_hour     = out_time_reg.hour;
    assign cur_minute   = out_time_reg.minute;
    assign cur_second   = out_time_reg.second;
    assign second_pulse = out_pulse_reg;

    // A ready receiver never blocks the input side.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    // An accepted word always sits in the input register on the next cycle.
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted word lost from input register");

    // Every delivered time has a month of 1 to 12, a legal time of day and a nonzero day.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cur_month >= 4'd1) && (cur_month <= 4'd12) &&
                      (cur_hour < 5'd24) && (cur_minute < 6'd60) &&
                      (cur_second < 6'd60) && (cur_day != 5'd0))
        else $error("result time out of range");

endmodule
